[src/round_robin_thread_scheduler_top_defines.svh]
// Assertion macros for the round-robin thread scheduler
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RRTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define RRTS_ASSERT(lbl, prop, msg)
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/rrts_pkg.sv]
// Types and codes shared by the round-robin thread scheduler
package rrts_pkg;

	typedef enum logic [2:0] {
		ACT_TICK, ACT_SPAWN, ACT_TERM, ACT_BLOCK, ACT_RESUME, ACT_SLEEP, ACT_QUERY
	} act_t;

	typedef enum logic [1:0] {
		TS_FREE, TS_READY, TS_RUN, TS_BLOCK
	} tstate_t;

	typedef enum logic [1:0] {
		STAT_OK, STAT_ERR, STAT_SHUT
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_TGT, S_RM_RD, S_RM, S_TK_RD, S_TK, S_SP_RD, S_SP,
		S_SW_RD, S_SW, S_POP, S_POP_W, S_NX, S_DONE
	} st_t;

	typedef struct packed {
		tstate_t     st;
		logic        sflag;
		logic [15:0] sleft;
		logic [31:0] quanta;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

[src/rrts_ram.sv]
// Generic simple dual-port RAM with registered read
module rrts_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/round_robin_thread_scheduler_top.sv]
// Round-robin thread scheduler: sequencer over slot and ready-queue memories
// Results leave in the cycle after the final state; a tick or spawn walks the slot
// memory and a removal walks the ready queue.
// Throughput: one transaction at a time; busy stays high until its result is issued.
// Reset: a clearing pass walks the slot memory; the same pass follows a shutdown.
// The receiver cannot stall the done strobe.
`include "round_robin_thread_scheduler_top_defines.svh"

module round_robin_thread_scheduler_top
	import rrts_pkg::*;
#(
	parameter int MAX_THREADS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [3:0]  thread_id,
	input  logic [15:0] sleep_quanta,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] value,
	output logic [3:0]  running_id,
	output logic [31:0] total_quanta
);

	localparam int TW = $clog2(MAX_THREADS);
	localparam int CW = $clog2(MAX_THREADS + 1);

	st_t st_q, st_d;
	logic [2:0]    act_q;
	logic [TW-1:0] tgt_q, cnt_q, head_q, cur_q;
	logic [15:0]   nq_q;
	logic [CW-1:0] r_q, w_q, len_q, live_q;
	logic [1:0]    res_st_q;
	logic [31:0]   res_val_q, total_q;
	logic          shut_q;

	logic              s_we;
	logic [TW-1:0]     s_waddr, s_raddr;
	slot_t             s_wdata, ent, nent;
	logic [SLOT_W-1:0] s_rdata;
	logic              f_we;
	logic [TW-1:0]     f_waddr, f_raddr, f_wdata, f_rdata;
	logic              push_req, push_en;
	logic [TW-1:0]     push_tid;

	logic [7:0]    tid8, cur8;
	logic [TW-1:0] tid_idx;
	logic          tid_ok, exists, last, q_empty;

	function automatic logic [TW-1:0] wrap_add(input logic [TW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(MAX_THREADS)) begin
			s = s - (CW+1)'(MAX_THREADS);
		end
		return s[TW-1:0];
	endfunction

	assign tid8    = {4'b0000, thread_id};
	assign tid_idx = tid8[TW-1:0];
	assign tid_ok  = {5'b00000, thread_id} < 9'(MAX_THREADS);
	assign cur8    = 8'(cur_q);
	assign ent     = slot_t'(s_rdata);
	assign exists  = ent.st != TS_FREE;
	assign last    = cnt_q == TW'(MAX_THREADS - 1);
	assign push_en = push_req && (len_q < CW'(MAX_THREADS));
	assign q_empty = (len_q == '0) && !push_en;
	assign busy    = st_q != S_IDLE;

	rrts_ram #(.W(SLOT_W), .D(MAX_THREADS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	rrts_ram #(.W(TW), .D(MAX_THREADS)) u_fifo_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_CLEAR: begin
				if (last) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (action)
						ACT_TICK:   st_d = S_TK_RD;
						ACT_SPAWN:  st_d = (live_q >= CW'(MAX_THREADS)) ? S_DONE : S_SP_RD;
						ACT_TERM:   st_d = (thread_id == 4'd0 || !tid_ok) ? S_DONE : S_TGT;
						ACT_BLOCK:  st_d = (thread_id == 4'd0 || !tid_ok) ? S_DONE : S_TGT;
						ACT_RESUME: st_d = tid_ok ? S_TGT : S_DONE;
						ACT_QUERY:  st_d = tid_ok ? S_TGT : S_DONE;
						ACT_SLEEP:  st_d = (cur_q == '0 || sleep_quanta == '0) ? S_DONE : S_SW;
						default:    st_d = S_DONE;
					endcase
				end
			end
			S_TGT: begin
				st_d = S_DONE;
				if (exists && act_q == ACT_TERM) begin
					st_d = S_RM_RD;
				end else if (exists && act_q == ACT_BLOCK) begin
					if (tgt_q == cur_q) begin
						st_d = S_SW_RD;
					end else if (ent.st != TS_BLOCK) begin
						st_d = S_RM_RD;
					end
				end
			end
			S_RM_RD: begin
				if (r_q == len_q) begin
					st_d = (act_q == ACT_TERM && tgt_q == cur_q) ? S_SW_RD : S_DONE;
				end else begin
					st_d = S_RM;
				end
			end
			S_RM:    st_d = S_RM_RD;
			S_TK_RD: st_d = S_TK;
			S_TK:    st_d = last ? S_SW_RD : S_TK_RD;
			S_SP_RD: st_d = S_SP;
			S_SP:    st_d = (ent.st == TS_FREE || last) ? S_DONE : S_SP_RD;
			S_SW_RD: st_d = S_SW;
			S_SW:    st_d = q_empty ? S_DONE : S_POP;
			S_POP:   st_d = S_POP_W;
			S_POP_W: st_d = S_NX;
			S_NX:    st_d = S_DONE;
			S_DONE:  st_d = shut_q ? S_CLEAR : S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_we     = 1'b0;
		s_waddr  = cnt_q;
		s_wdata  = ent;
		s_raddr  = cnt_q;
		f_we     = 1'b0;
		f_waddr  = wrap_add(head_q, len_q);
		f_wdata  = push_tid;
		f_raddr  = head_q;
		push_req = 1'b0;
		push_tid = cnt_q;
		nent     = ent;
		case (st_q)
			S_CLEAR: begin
				s_we    = 1'b1;
				s_wdata = '0;
				if (cnt_q == '0) begin
					s_wdata.st     = TS_RUN;
					s_wdata.quanta = 32'd1;
				end
			end
			S_IDLE: begin
				s_raddr = (action == ACT_SLEEP) ? cur_q : tid_idx;
			end
			S_TGT: begin
				s_waddr = tgt_q;
				if (exists) begin
					case (act_q)
						ACT_TERM: begin
							s_we    = 1'b1;
							s_wdata = '0;
						end
						ACT_BLOCK: begin
							s_we       = (tgt_q != cur_q) && (ent.st != TS_BLOCK);
							s_wdata.st = TS_BLOCK;
						end
						ACT_RESUME: begin
							s_we       = ent.st == TS_BLOCK;
							s_wdata.st = TS_READY;
							push_req   = (ent.st == TS_BLOCK) && !ent.sflag;
							push_tid   = tgt_q;
						end
						default: s_we = 1'b0;
					endcase
				end
			end
			S_RM_RD: begin
				f_raddr = wrap_add(head_q, r_q);
			end
			S_RM: begin
				f_we    = f_rdata != tgt_q;
				f_waddr = wrap_add(head_q, w_q);
				f_wdata = f_rdata;
			end
			S_TK: begin
				s_we = 1'b1;
				if (ent.st != TS_FREE && ent.sleft != '0) begin
					nent.sleft = ent.sleft - 16'd1;
					if (ent.sleft == 16'd1 && ent.sflag) begin
						nent.sflag = 1'b0;
						if (ent.st != TS_BLOCK) begin
							nent.st  = TS_READY;
							push_req = 1'b1;
						end
					end
				end
				s_wdata = nent;
			end
			S_SP: begin
				s_we     = ent.st == TS_FREE;
				s_wdata  = '0;
				s_wdata.st = TS_READY;
				push_req = ent.st == TS_FREE;
			end
			S_SW_RD: begin
				s_raddr = cur_q;
			end
			S_SW: begin
				s_we    = 1'b1;
				s_waddr = cur_q;
				if (act_q == ACT_SLEEP) begin
					nent.sflag = 1'b1;
					nent.sleft = nq_q;
				end
				if (act_q == ACT_BLOCK) begin
					nent.st = TS_BLOCK;
				end else if (act_q != ACT_TERM) begin
					nent.st  = TS_READY;
					push_req = !nent.sflag;
					push_tid = cur_q;
				end
				if (q_empty && nent.st != TS_FREE) begin
					nent.st = TS_RUN;
				end
				s_wdata = nent;
			end
			S_POP_W: begin
				s_raddr = f_rdata;
			end
			S_NX: begin
				s_we           = 1'b1;
				s_waddr        = cur_q;
				s_wdata.st     = TS_RUN;
				s_wdata.quanta = ent.quanta + 32'd1;
			end
			default: s_we = 1'b0;
		endcase
		if (st_q != S_RM) begin
			f_we = push_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_CLEAR;
			cnt_q   <= '0;
			head_q  <= '0;
			len_q   <= '0;
			cur_q   <= '0;
			total_q <= 32'd1;
			live_q  <= CW'(1);
			shut_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= st_q == S_DONE;
			if (push_en && st_q != S_RM) begin
				len_q <= len_q + CW'(1);
			end
			case (st_q)
				S_CLEAR: begin
					cnt_q <= last ? '0 : cnt_q + TW'(1);
					if (last) begin
						shut_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q     <= action;
						tgt_q     <= tid_idx;
						nq_q      <= sleep_quanta;
						r_q       <= '0;
						w_q       <= '0;
						res_val_q <= '0;
						res_st_q  <= STAT_ERR;
						cnt_q     <= (action == ACT_SPAWN) ? TW'(1) : '0;
						if (action == ACT_TICK) begin
							res_st_q <= STAT_OK;
						end
						if (action == ACT_SLEEP && cur_q != '0 && sleep_quanta != '0) begin
							res_st_q <= STAT_OK;
						end
						if (action == ACT_TERM && thread_id == 4'd0) begin
							res_st_q <= STAT_SHUT;
							shut_q   <= 1'b1;
							cur_q    <= '0;
							total_q  <= 32'd1;
							live_q   <= CW'(1);
							head_q   <= '0;
							len_q    <= '0;
						end
					end
				end
				S_TGT: begin
					if (exists) begin
						res_st_q <= STAT_OK;
						if (act_q == ACT_QUERY) begin
							res_val_q <= ent.quanta;
						end
						if (act_q == ACT_TERM) begin
							live_q <= live_q - CW'(1);
						end
					end
				end
				S_RM_RD: begin
					if (r_q == len_q) begin
						len_q <= w_q;
					end
				end
				S_RM: begin
					r_q <= r_q + CW'(1);
					if (f_rdata != tgt_q) begin
						w_q <= w_q + CW'(1);
					end
				end
				S_TK: begin
					cnt_q <= cnt_q + TW'(1);
				end
				S_SP: begin
					if (ent.st == TS_FREE) begin
						live_q    <= live_q + CW'(1);
						res_val_q <= 32'(cnt_q);
						res_st_q  <= STAT_OK;
					end else begin
						cnt_q <= cnt_q + TW'(1);
					end
				end
				S_POP_W: begin
					cur_q   <= f_rdata;
					total_q <= total_q + 32'd1;
					head_q  <= wrap_add(head_q, CW'(1));
					len_q   <= len_q - CW'(1);
				end
				S_DONE: begin
					status       <= res_st_q;
					value        <= res_val_q;
					running_id   <= cur8[3:0];
					total_quanta <= total_q;
				end
				default: begin
				end
			endcase
		end
	end

	`RRTS_ASSERT(a_len_bound, len_q <= CW'(MAX_THREADS), "ready queue overrun")
	`RRTS_ASSERT(a_live_bound, live_q >= CW'(1) && live_q <= CW'(MAX_THREADS), "live count out of range")
	`RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "transaction accepted without leaving idle")
	`RRTS_ASSERT_NEXT(a_done_pulse, st_q == S_DONE, done && !busy == (!shut_q || !$past(shut_q)), "missing result strobe")

endmodule
